@@ rtl/core/lpp_pkg.sv @@
// shared types and constants of the loop playback position generator
package lpp_pkg;

	// fixed point layout of the frame position
	localparam int FRAC_BITS  = 16;
	localparam int MAX_FRAMES = 4096;
	localparam int POS_W      = 28;
	localparam int FRAME_W    = 12;
	localparam int COUNT_W    = 13;
	localparam int RATE_W     = 20;
	localparam int ELAPSED_W  = 16;
	localparam int PROD_FRAC  = 28;
	localparam int SHIFT_DOWN = PROD_FRAC - FRAC_BITS;

	// internal widths
	localparam int PROD_W  = ELAPSED_W + 1 + RATE_W;
	localparam int STEP_W  = PROD_W - SHIFT_DOWN;
	localparam int STATE_W = 31;
	localparam int EDGE_W  = POS_W + 1;

	// register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic signed [RATE_W-1:0] RATE_RESET  = 20'sd7680;
	localparam logic [COUNT_W-1:0]       COUNT_RESET = 13'd1;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PLAY    = 2'd1,
		OP_SET     = 2'd2,
		OP_RESTART = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_RATE        = 3'd0,
		REG_FRAME_COUNT = 3'd1,
		REG_LOOP_ENABLE = 3'd2,
		REG_PING_PONG   = 3'd3,
		REG_LOOP_ONSET  = 3'd4,
		REG_LOOP_SIZE   = 3'd5
	} reg_idx_t;

endpackage

@@ rtl/core/loop_playback_position.sv @@
// loop playback position generator: register port, input stage, update logic, result register
//
// loop_playback_position keeps a frame position in unsigned Q12.16 frames for a
// buffer of video frames. each accepted item is one of four commands: a tick that
// advances the position by elapsed time (2^-20 s units) times the rate register,
// play from a position, set a position, or restart the loop. with looping on the
// position wraps at the loop edges, or bounces in ping-pong mode, and the result
// item flags the wrap; with looping off it stops on leaving the buffer. every
// item gives exactly one result item holding the clamped position, the rounded
// nearest frame, the play state and the wrap flag. an item is held in the input
// register and its result is then taken into the result register, and a new item is
// taken every cycle while the result side keeps up. the rate limit is the single
// 17x20 multiply, rounding add and bound compares between the input register and
// the position state, which together form a loop through the state register.
// configuration goes over an apb-style port with no wait states; the user must
// write it only while no item is in flight, the block itself does not enforce this.
module loop_playback_position
	import lpp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// input items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [ELAPSED_W-1:0]     elapsed,
	input  logic [POS_W-1:0]         new_position,
	// result items
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [POS_W-1:0]         position,
	output logic [FRAME_W-1:0]       nearest_frame,
	output logic                     playing,
	output logic                     loop_restart
);

	// configuration registers
	logic signed [RATE_W-1:0] rate_q;
	logic [COUNT_W-1:0]       frame_count_q;
	logic                     loop_enable_q;
	logic                     ping_pong_q;
	logic [POS_W-1:0]         loop_onset_q;
	logic [POS_W-1:0]         loop_size_q;

	// playback state
	logic signed [STATE_W-1:0] play_pos_q;
	logic                      dir_rev_q;
	logic                      is_playing_q;
	logic [POS_W-1:0]          act_onset_q;
	logic [POS_W-1:0]          act_size_q;

	// input stage
	logic                  valid_s1;
	opcode_t               opcode_s1;
	logic [ELAPSED_W-1:0]  elapsed_s1;
	logic [POS_W-1:0]      new_pos_s1;

	// result register
	logic                  out_valid_q;
	logic [POS_W-1:0]      position_q;
	logic [FRAME_W-1:0]    nearest_q;
	logic                  playing_q;
	logic                  restart_q;

	// handshake
	logic advance;
	logic fire;
	logic in_take;
	logic wr_en;

	// update logic outputs
	logic signed [STATE_W-1:0] pos_nxt;
	logic                      dir_nxt;
	logic                      playing_nxt;
	logic [POS_W-1:0]          onset_nxt;
	logic [POS_W-1:0]          size_nxt;
	logic                      restart_nxt;
	logic [POS_W-1:0]          pos_out;
	logic [FRAME_W-1:0]        nearest_out;

	// ------------------------------------------------------------------
	// register port: writes on the access phase, reads are combinational
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q        <= RATE_RESET;
			frame_count_q <= COUNT_RESET;
			loop_enable_q <= 1'b0;
			ping_pong_q   <= 1'b0;
			loop_onset_q  <= '0;
			loop_size_q   <= '1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_RATE:        rate_q        <= pwdata[RATE_W-1:0];
				REG_FRAME_COUNT: frame_count_q <= pwdata[COUNT_W-1:0];
				REG_LOOP_ENABLE: loop_enable_q <= pwdata[0];
				REG_PING_PONG:   ping_pong_q   <= pwdata[0];
				REG_LOOP_ONSET:  loop_onset_q  <= pwdata[POS_W-1:0];
				REG_LOOP_SIZE:   loop_size_q   <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[4:2]))
			REG_RATE:        prdata = {{(DATA_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
			REG_FRAME_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, frame_count_q};
			REG_LOOP_ENABLE: prdata = {{(DATA_W-1){1'b0}}, loop_enable_q};
			REG_PING_PONG:   prdata = {{(DATA_W-1){1'b0}}, ping_pong_q};
			REG_LOOP_ONSET:  prdata = {{(DATA_W-POS_W){1'b0}}, loop_onset_q};
			REG_LOOP_SIZE:   prdata = {{(DATA_W-POS_W){1'b0}}, loop_size_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// item flow: input register, then result register with its own valid
	// ------------------------------------------------------------------
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1  <= opcode_t'(opcode);
			elapsed_s1 <= elapsed;
			new_pos_s1 <= new_position;
		end
	end

	// ------------------------------------------------------------------
	// position update for the item in the input register
	// ------------------------------------------------------------------
	always_comb begin
		logic [COUNT_W-1:0]        n_eff;
		logic [FRAME_W-1:0]        last_idx;
		logic [POS_W-1:0]          len;
		logic signed [STATE_W-1:0] len_s;
		logic signed [PROD_W-1:0]  prod;
		logic signed [PROD_W-1:0]  prod_rnd;
		logic signed [STEP_W-1:0]  step;
		logic signed [STEP_W-1:0]  step_dir;
		logic signed [STATE_W-1:0] pos_raw;
		logic [POS_W-1:0]          onset_c;
		logic [POS_W-1:0]          size_lim;
		logic [POS_W-1:0]          size_c;
		logic [EDGE_W-1:0]         edge_hi;
		logic [EDGE_W-1:0]         reg_end;
		logic                      rate_pos;
		logic                      forward;
		logic                      crossed;
		logic signed [STATE_W-1:0] pos_clamp;
		logic [POS_W:0]            pos_half;

		// last frame as a Q12.16 position; zero frames behave as one
		if (frame_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (frame_count_q > COUNT_W'(MAX_FRAMES)) begin
			n_eff = COUNT_W'(MAX_FRAMES);
		end else begin
			n_eff = frame_count_q;
		end
		last_idx = FRAME_W'(n_eff - COUNT_W'(1));
		len      = {last_idx, {FRAC_BITS{1'b0}}};
		len_s    = $signed({{(STATE_W-POS_W){1'b0}}, len});

		// step = elapsed * rate with 28 fraction bits, rounded half up to 16
		prod     = $signed({{(PROD_W-ELAPSED_W){1'b0}}, elapsed_s1})
			* $signed({{(PROD_W-RATE_W){rate_q[RATE_W-1]}}, rate_q});
		prod_rnd = prod + $signed(PROD_W'(1) << (SHIFT_DOWN - 1));
		step     = prod_rnd[PROD_W-1:SHIFT_DOWN];
		step_dir = (loop_enable_q && dir_rev_q) ? -step : step;
		pos_raw  = play_pos_q + $signed({{(STATE_W-STEP_W){step_dir[STEP_W-1]}}, step_dir});

		// loop bounds held inside the buffer
		onset_c  = (act_onset_q > len) ? len : act_onset_q;
		size_lim = len - onset_c;
		size_c   = (act_size_q > size_lim) ? size_lim : act_size_q;
		edge_hi  = {1'b0, onset_c} + {1'b0, size_c};
		reg_end  = {1'b0, loop_onset_q} + {1'b0, loop_size_q};

		rate_pos = !rate_q[RATE_W-1] && (rate_q != '0);
		forward  = (rate_q == '0) || (rate_pos != dir_rev_q);
		if (forward) begin
			crossed = pos_raw > $signed({{(STATE_W-EDGE_W){1'b0}}, edge_hi});
		end else begin
			crossed = pos_raw < $signed({{(STATE_W-POS_W){1'b0}}, onset_c});
		end

		pos_nxt     = play_pos_q;
		dir_nxt     = dir_rev_q;
		playing_nxt = is_playing_q;
		onset_nxt   = act_onset_q;
		size_nxt    = act_size_q;
		restart_nxt = 1'b0;

		case (opcode_s1)
			OP_TICK: begin
				if (is_playing_q && loop_enable_q) begin
					pos_nxt   = pos_raw;
					onset_nxt = onset_c;
					size_nxt  = size_c;
					if (crossed) begin
						// wrap or bounce at the far edge, bounds reload unclamped
						restart_nxt = 1'b1;
						onset_nxt   = loop_onset_q;
						size_nxt    = loop_size_q;
						if (ping_pong_q) begin
							dir_nxt = !dir_rev_q;
						end
						if (ping_pong_q == forward) begin
							pos_nxt = $signed({{(STATE_W-EDGE_W){1'b0}}, reg_end});
						end else begin
							pos_nxt = $signed({{(STATE_W-POS_W){1'b0}}, loop_onset_q});
						end
					end
				end else if (is_playing_q) begin
					// play once: leaving the buffer stops playback
					pos_nxt = pos_raw;
					if (pos_raw < 0 || pos_raw >= len_s) begin
						playing_nxt = 1'b0;
					end
				end
				// a tick always leaves the stored position inside the buffer
				if (pos_nxt < 0) begin
					pos_nxt = '0;
				end else if (pos_nxt > len_s) begin
					pos_nxt = len_s;
				end
			end
			OP_PLAY: begin
				pos_nxt     = $signed({{(STATE_W-POS_W){1'b0}}, new_pos_s1});
				dir_nxt     = 1'b0;
				playing_nxt = 1'b1;
			end
			OP_SET: begin
				pos_nxt = $signed({{(STATE_W-POS_W){1'b0}}, new_pos_s1});
				dir_nxt = 1'b0;
			end
			OP_RESTART: begin
				if (loop_enable_q) begin
					onset_nxt = loop_onset_q;
					size_nxt  = loop_size_q;
					if (!rate_q[RATE_W-1]) begin
						pos_nxt = $signed({{(STATE_W-POS_W){1'b0}}, loop_onset_q});
					end else begin
						pos_nxt = $signed({{(STATE_W-EDGE_W){1'b0}}, reg_end});
					end
				end
			end
			default: ;
		endcase

		// reported position clamped to the buffer, nearest frame rounds half up
		if (pos_nxt < 0) begin
			pos_clamp = '0;
		end else if (pos_nxt > len_s) begin
			pos_clamp = len_s;
		end else begin
			pos_clamp = pos_nxt;
		end
		pos_out     = pos_clamp[POS_W-1:0];
		pos_half    = {1'b0, pos_out} + (POS_W+1)'(1 << (FRAC_BITS - 1));
		nearest_out = pos_half[FRAC_BITS +: FRAME_W];
	end

	// ------------------------------------------------------------------
	// state and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_pos_q   <= '0;
			dir_rev_q    <= 1'b0;
			is_playing_q <= 1'b0;
			act_onset_q  <= '0;
			act_size_q   <= '1;
		end else if (fire) begin
			play_pos_q   <= pos_nxt;
			dir_rev_q    <= dir_nxt;
			is_playing_q <= playing_nxt;
			act_onset_q  <= onset_nxt;
			act_size_q   <= size_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			position_q <= pos_out;
			nearest_q  <= nearest_out;
			playing_q  <= playing_nxt;
			restart_q  <= restart_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = position_q;
	assign nearest_frame = nearest_q;
	assign playing       = playing_q;
	assign loop_restart  = restart_q;

endmodule

@@ rtl/core/lpp_checker.sv @@
// port-level checks of the loop playback position generator and their binding
module lpp_checker
	import lpp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [POS_W-1:0]   position,
	input logic [FRAME_W-1:0] nearest_frame,
	input logic               playing,
	input logic               loop_restart
);

	logic [POS_W:0] half_up;
	assign half_up = {1'b0, position} + (POS_W+1)'(1 << (FRAC_BITS - 1));

	// a stalled result item holds its valid, position and play state
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(playing))
		else $error("result item changed while stalled");

	// nearest frame is the position rounded half up
	a_nearest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nearest_frame == half_up[FRAC_BITS +: FRAME_W])
		else $error("nearest frame does not match position");

	// only a running loop can wrap
	a_restart_playing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && loop_restart |-> playing)
		else $error("loop restart flagged while stopped");

endmodule

bind loop_playback_position lpp_checker u_lpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.position      (position),
	.nearest_frame (nearest_frame),
	.playing       (playing),
	.loop_restart  (loop_restart)
);

@@ tb/tb_loop_playback_position.sv @@
// self-checking testbench for the loop playback position generator
module tb_loop_playback_position;
	import lpp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// rate extremes in signed q12.8
	localparam logic signed [RATE_W-1:0] RATE_MAX = 20'sd524287;
	localparam logic signed [RATE_W-1:0] RATE_MIN = -20'sd524288;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 80;

	// one expected result item
	typedef struct {
		logic [POS_W-1:0]   position;
		logic [FRAME_W-1:0] nearest;
		bit                 playing;
		bit                 restart;
	} frame_result_t;

	// predicts the position state machine and checks result items in order
	class position_scoreboard;
		// register copies
		logic signed [RATE_W-1:0] rate_q;
		logic [COUNT_W-1:0]       frame_count_q;
		bit                       loop_on;
		bit                       bounce_on;
		logic [POS_W-1:0]         onset_q;
		logic [POS_W-1:0]         size_q;
		// position state copies
		logic signed [STATE_W-1:0] pos_q;
		bit                        reversed;
		bit                        running;
		bit                        wrapped;
		logic [POS_W-1:0]          act_onset;
		logic [POS_W-1:0]          act_size;

		frame_result_t expected_q[$];
		int errors;
		int items_noted;
		int results_checked;
		int wraps_seen;

		function new();
			rate_q = RATE_RESET;
			frame_count_q = COUNT_RESET;
			loop_on = 0;
			bounce_on = 0;
			onset_q = '0;
			size_q = '1;
			pos_q = '0;
			reversed = 0;
			running = 0;
			wrapped = 0;
			act_onset = '0;
			act_size = '1;
			errors = 0;
			items_noted = 0;
			results_checked = 0;
			wraps_seen = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_RATE:        rate_q = value[RATE_W-1:0];
				REG_FRAME_COUNT: frame_count_q = value[COUNT_W-1:0];
				REG_LOOP_ENABLE: loop_on = value[0];
				REG_PING_PONG:   bounce_on = value[0];
				REG_LOOP_ONSET:  onset_q = value[POS_W-1:0];
				REG_LOOP_SIZE:   size_q = value[POS_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		// position of the last frame, frame count limited to 1..MAX_FRAMES
		function longint last_frame_pos();
			longint n;
			n = longint'(frame_count_q);
			if (n < 1) n = 1;
			if (n > MAX_FRAMES) n = MAX_FRAMES;
			return (n - 1) << FRAC_BITS;
		endfunction

		function void reload();
			act_onset = onset_q;
			act_size = size_q;
		endfunction

		function void note_item(opcode_t op, logic [ELAPSED_W-1:0] el,
				logic [POS_W-1:0] np);
			longint lim, p, stride, lo, span, shown;
			bit fwd;
			frame_result_t r;
			wrapped = 0;
			items_noted++;
			lim = last_frame_pos();
			case (op)
				OP_TICK: begin
					p = pos_q;
					if (running) begin
						// elapsed times rate has 28 fraction bits, round half up to 16
						stride = (longint'(el) * longint'(rate_q)
							+ (longint'(1) << (SHIFT_DOWN - 1))) >>> SHIFT_DOWN;
						if (loop_on) begin
							if (reversed) stride = -stride;
							p += stride;
							lo = clip(longint'(act_onset), 0, lim);
							span = clip(longint'(act_size), 0, lim - lo);
							act_onset = POS_W'(lo);
							act_size = POS_W'(span);
							fwd = (rate_q == 0) || ((rate_q > 0) != reversed);
							if (fwd && p > lo + span) begin
								wrapped = 1;
								reload();
								if (bounce_on) begin
									reversed = !reversed;
									p = longint'(act_onset) + longint'(act_size);
								end else begin
									p = longint'(act_onset);
								end
							end else if (!fwd && p < lo) begin
								wrapped = 1;
								reload();
								if (bounce_on) begin
									reversed = !reversed;
									p = longint'(act_onset);
								end else begin
									p = longint'(act_onset) + longint'(act_size);
								end
							end
						end else begin
							p += stride;
							if (p < 0 || p >= lim) running = 0;
						end
					end
					pos_q = STATE_W'(clip(p, 0, lim));
				end
				OP_PLAY: begin
					pos_q = STATE_W'(np);
					reversed = 0;
					running = 1;
				end
				OP_SET: begin
					pos_q = STATE_W'(np);
					reversed = 0;
				end
				default: begin
					if (loop_on) begin
						reload();
						pos_q = STATE_W'((rate_q >= 0) ? longint'(act_onset)
							: longint'(act_onset) + longint'(act_size));
					end
				end
			endcase
			shown = clip(pos_q, 0, lim);
			r.position = shown[POS_W-1:0];
			r.nearest = FRAME_W'((shown + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
			r.playing = running;
			r.restart = wrapped;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(logic [POS_W-1:0] pos, logic [FRAME_W-1:0] nf,
				logic pl, logic lr);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				$error("result item with nothing expected: position %0h", pos);
				errors++;
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			results_checked++;
			if (want.restart) wraps_seen++;
			if (pos !== want.position) begin
				$error("position: expected %0h, got %0h", want.position, pos);
				errors++;
			end
			if (nf !== want.nearest) begin
				$error("nearest_frame: expected %0d, got %0d", want.nearest, nf);
				errors++;
			end
			if (pl !== want.playing) begin
				$error("playing: expected %0b, got %0b", want.playing, pl);
				errors++;
			end
			if (lr !== want.restart) begin
				$error("loop_restart: expected %0b, got %0b", want.restart, lr);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           opcode;
	logic [ELAPSED_W-1:0] elapsed;
	logic [POS_W-1:0]     new_position;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [POS_W-1:0]     position;
	logic [FRAME_W-1:0]   nearest_frame;
	logic                 playing;
	logic                 loop_restart;

	position_scoreboard sb = new();

	// percent of cycles in which each side holds off, zero for a steady stretch
	int idle_pct = 24;
	int cycles = 0;
	int setups = 0;

	loop_playback_position dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.elapsed      (elapsed),
		.new_position (new_position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.nearest_frame(nearest_frame),
		.playing      (playing),
		.loop_restart (loop_restart)
	);

	always #6 clk = ~clk;

	// monitor: input items are noted before results are checked, both on pre-edge values
	always @(posedge clk) begin
		cycles++;
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(opcode_t'(opcode), elapsed, new_position);
			if (out_valid && out_ready)
				sb.check_result(position, nearest_frame, playing, loop_restart);
		end
	end

	// watchdog against a hung handshake
	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// register write: setup cycle, then access cycle; the predictor follows at the write edge
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// all six registers, written only while nothing is in flight
	task automatic load_setup(logic signed [RATE_W-1:0] r, logic [COUNT_W-1:0] fc,
			bit le, bit pp, logic [POS_W-1:0] onset, logic [POS_W-1:0] size);
		write_reg(REG_RATE, {{(DATA_W - RATE_W){1'b0}}, r});
		write_reg(REG_FRAME_COUNT, DATA_W'(fc));
		write_reg(REG_LOOP_ENABLE, DATA_W'(le));
		write_reg(REG_PING_PONG, DATA_W'(pp));
		write_reg(REG_LOOP_ONSET, DATA_W'(onset));
		write_reg(REG_LOOP_SIZE, DATA_W'(size));
		setups++;
	endtask

	// offer one item; valid stays high on return so back-to-back items need no dip
	task automatic send_item(opcode_t op, logic [ELAPSED_W-1:0] el, logic [POS_W-1:0] np);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		elapsed <= el;
		new_position <= np;
		@(posedge clk);
		while (!(in_valid && in_ready)) @(posedge clk);
	endtask

	// stop sending and wait for every expected result, plus a margin for the pipeline
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int frames, pick;
		logic signed [RATE_W-1:0] r;
		logic [COUNT_W-1:0] fc;
		logic [POS_W-1:0] onset, size, np, span;
		logic [ELAPSED_W-1:0] el;
		opcode_t op;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		opcode <= OP_TICK;
		elapsed <= '0;
		new_position <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single frame, looping off; tick while stopped,
		// play past the end, restart ignored with looping off
		send_item(OP_TICK, '1, '1);
		send_item(OP_PLAY, '0, '1);
		send_item(OP_TICK, '1, '0);
		send_item(OP_SET, '0, '0);
		send_item(OP_RESTART, '1, '1);
		drain();

		// fastest forward rate, full buffer, play once and run off the end
		load_setup(RATE_MAX, COUNT_W'(MAX_FRAMES), 0, 0, '0, '1);
		send_item(OP_PLAY, '0, '0);
		send_item(OP_TICK, '1, '0);
		send_item(OP_PLAY, '0, POS_W'(((MAX_FRAMES - 1) << FRAC_BITS) - 1));
		send_item(OP_TICK, '1, '0);
		drain();

		// most negative rate, plain loop: restart lands on the far edge,
		// falling below onset wraps back to onset plus size
		load_setup(RATE_MIN, 13'd64, 1, 0, POS_W'(10 << FRAC_BITS), POS_W'(20 << FRAC_BITS));
		send_item(OP_PLAY, '0, POS_W'(15 << FRAC_BITS));
		send_item(OP_RESTART, '0, '0);
		send_item(OP_TICK, '1, '0);
		send_item(OP_TICK, 16'd2000, '0);
		drain();

		// zero rate counts as forward; bounds beyond the buffer get clamped,
		// a wrap reloads them unclamped
		load_setup('0, 13'd16, 1, 1, '1, '1);
		send_item(OP_PLAY, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_PLAY, '0, '1);
		send_item(OP_TICK, '1, '0);
		drain();

		// ping-pong in a short loop: bounce at the top, run back, bounce at the bottom
		load_setup(RATE_RESET, 13'd8, 1, 1, POS_W'(2 << FRAC_BITS), POS_W'(3 << FRAC_BITS));
		send_item(OP_PLAY, '0, POS_W'(4 << FRAC_BITS));
		repeat (4) send_item(OP_TICK, '1, '0);
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// one phase runs without any hold-off on either side
			idle_pct = (ph == 4) ? 0 : 24;

			pick = $urandom_range(0, 9);
			case (pick)
				0: r = RATE_MIN;
				1: r = RATE_MAX;
				2: r = '0;
				3, 4: r = RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
				default: begin
					r = RATE_W'($urandom_range(1, 60000));
					if ($urandom_range(0, 1)) r = -r;
				end
			endcase
			pick = $urandom_range(0, 7);
			case (pick)
				0: fc = '0;
				1: fc = 13'd1;
				2: fc = COUNT_W'(MAX_FRAMES);
				3: fc = '1;
				4: fc = COUNT_W'($urandom_range(MAX_FRAMES + 1, (1 << COUNT_W) - 1));
				default: fc = COUNT_W'($urandom_range(2, 64));
			endcase
			frames = (fc == 0) ? 1 : ((fc > MAX_FRAMES) ? MAX_FRAMES : int'(fc));
			span = POS_W'((frames - 1) << FRAC_BITS);
			// bounds mostly inside the buffer, sometimes anywhere, size sometimes empty
			onset = ($urandom_range(0, 4) == 0) ? POS_W'($urandom)
				: POS_W'($urandom_range(0, span));
			pick = $urandom_range(0, 5);
			size = (pick == 0) ? '0 : (pick == 1) ? POS_W'($urandom)
				: POS_W'($urandom_range(0, span / 2));
			load_setup(r, fc, $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 1,
				onset, size);

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// one forced pause until the pipeline is empty
				if (ph == 2 && i == ITEMS_PER_PHASE / 2) drain();
				pick = $urandom_range(0, 99);
				op = (pick < 62) ? OP_TICK : (pick < 74) ? OP_PLAY
					: (pick < 84) ? OP_SET : OP_RESTART;
				el = $urandom_range(0, 1) ? ELAPSED_W'($urandom) : ELAPSED_W'($urandom_range(0, 8000));
				np = ($urandom_range(0, 7) == 0) ? POS_W'($urandom)
					: POS_W'($urandom_range(0, span));
				send_item(op, el, np);
			end
			drain();
		end

		idle_pct = 24;
		repeat (8) @(posedge clk);
		$display("covered %0d items and %0d results over %0d register settings",
			sb.items_noted, sb.results_checked, setups);
		$display("%0d results carried a loop wrap or bounce", sb.wraps_seen);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
